@@ design/uvsg_pkg.sv @@
package uvsg_pkg;

    localparam int MAX_SEGMENTS = 256;
    localparam int ANGLE_BITS   = 16;

    // port widths fixed by the interface
    localparam int SEG_REG_W = 9;
    localparam int IDX_W     = 9;
    localparam int POS_W     = 16;

    localparam int FRAC_BITS = 16;
    localparam int U_W       = FRAC_BITS + 1;
    localparam int CNT_W     = $clog2(MAX_SEGMENTS + 1);
    localparam int N_W       = CNT_W + FRAC_BITS;

    localparam int QS    = ANGLE_BITS - 2;
    localparam int MAG_W = 31;

    localparam logic [MAG_W-1:0] Q30_ONE     = MAG_W'(64'd1 << 30);
    localparam logic [30:0]      HALF_PI_Q30 = 31'd1686629713;
    localparam logic [14:0]      Q14_MAX     = 15'd16384;

    // Horner steps of the sine series, innermost first
    localparam int NSTEP = 4;
    localparam logic [6:0]  DIVISOR [NSTEP] = '{7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [31:0] RECIP   [NSTEP] = '{
        32'((64'd1 << 32) / 72), 32'((64'd1 << 32) / 42),
        32'((64'd1 << 32) / 20), 32'((64'd1 << 32) / 6)};

    localparam int DIV_STAGES = U_W;
    localparam int SIN_STAGES = 3 + 2 * NSTEP + (NSTEP - 1) + 2;
    localparam int LATENCY    = 1 + DIV_STAGES + 1 + SIN_STAGES + 2;

    typedef logic [ANGLE_BITS-1:0] t_phase;

    // Q16 fraction to phase with 'bits' fraction bits, wrapped to one turn
    function automatic t_phase phase_of(input logic [U_W-1:0] f, input int bits);
        logic [63:0] w;
        begin
            if (bits >= FRAC_BITS) begin
                w = 64'(f) << (bits - FRAC_BITS);
            end else begin
                w = (64'(f) + (64'd1 << (FRAC_BITS - bits - 1))) >> (FRAC_BITS - bits);
            end
            return w[ANGLE_BITS-1:0];
        end
    endfunction

    // saturate a rounded magnitude and apply the sign; zero stays positive
    function automatic logic [POS_W-1:0] q14_of(input logic [16:0] m, input logic neg);
        logic [16:0] c;
        begin
            c = (m > 17'(Q14_MAX)) ? 17'(Q14_MAX) : m;
            if (neg && (c != 17'd0)) begin
                return POS_W'(17'h10000 - c);
            end
            return POS_W'(c);
        end
    endfunction

endpackage

@@ design/uvsg_div.sv @@
module uvsg_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [uvsg_pkg::N_W-1:0]    i_num,
    input  logic [uvsg_pkg::CNT_W-1:0]  i_den,
    output logic                        o_valid,
    output logic [uvsg_pkg::U_W-1:0]    o_quo
);
    import uvsg_pkg::*;

    // one quotient bit per stage, restoring
    logic             r_v   [DIV_STAGES];
    logic [N_W-1:0]   r_num [DIV_STAGES];
    logic [CNT_W-1:0] r_den [DIV_STAGES];
    logic [CNT_W-1:0] r_rem [DIV_STAGES];
    logic [U_W-1:0]   r_quo [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
        localparam int B = U_W - 1 - i;
        logic             v_in;
        logic [N_W-1:0]   num_in;
        logic [CNT_W-1:0] den_in;
        logic [CNT_W-1:0] rem_in;
        logic [U_W-1:0]   quo_in;
        logic [CNT_W:0]   trial;
        logic             ge;

        if (i == 0) begin : g_first
            assign v_in   = i_valid;
            assign num_in = i_num;
            assign den_in = i_den;
            assign rem_in = CNT_W'(i_num >> U_W);
            assign quo_in = '0;
        end else begin : g_next
            assign v_in   = r_v[i-1];
            assign num_in = r_num[i-1];
            assign den_in = r_den[i-1];
            assign rem_in = r_rem[i-1];
            assign quo_in = r_quo[i-1];
        end

        assign trial = {rem_in, num_in[B]};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else begin
                r_v[i] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_num[i] <= num_in;
            r_den[i] <= den_in;
            r_rem[i] <= ge ? CNT_W'(trial - {1'b0, den_in}) : CNT_W'(trial);
            r_quo[i] <= quo_in | (U_W'(ge) << B);
        end
    end

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_quo   = r_quo[DIV_STAGES-1];

endmodule

@@ design/uvsg_sin.sv @@
module uvsg_sin (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  uvsg_pkg::t_phase            i_phase,
    output logic                        o_valid,
    output logic [uvsg_pkg::MAG_W-1:0]  o_mag,
    output logic                        o_neg
);
    import uvsg_pkg::*;

    localparam logic [QS:0] QUARTER = (QS+1)'(1) << QS;

    // fold to the first quadrant
    logic          r1_v, r1_neg;
    logic [QS:0]   r1_r;
    logic [QS:0]   fold_r;

    // angle in Q30
    logic          r2_v, r2_neg;
    logic [QS+31:0] r2_prod;
    logic [30:0]   t_ang;

    // square
    logic          r3_v, r3_neg;
    logic [30:0]   r3_t;
    logic [61:0]   r3_sq;

    // reciprocal multiply (M), correction (C); Horner product (P) sits in each later step
    logic          r_mv [NSTEP], r_mneg [NSTEP], r_cv [NSTEP], r_cneg [NSTEP];
    logic [30:0]   r_mt [NSTEP], r_ct [NSTEP];
    logic [31:0]   r_mt2 [NSTEP], r_ct2 [NSTEP], r_mx [NSTEP];
    logic [63:0]   r_mm [NSTEP];
    logic [MAG_W-1:0] r_ca [NSTEP];

    // final product and clamp
    logic          rs_v, rs_neg, rf_v, rf_neg;
    logic [61:0]   rs_prod;
    logic [MAG_W-1:0] rf_mag;
    logic [31:0]   s_raw;
    logic [MAG_W-1:0] s_sat;

    assign fold_r = i_phase[ANGLE_BITS-2] ? QUARTER - {1'b0, i_phase[QS-1:0]}
                                          : {1'b0, i_phase[QS-1:0]};
    assign t_ang  = r2_prod[QS+30:QS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_r    <= fold_r;
        r1_neg  <= i_phase[ANGLE_BITS-1];
        r2_prod <= (QS+32)'(r1_r) * (QS+32)'(HALF_PI_Q30);
        r2_neg  <= r1_neg;
        r3_t    <= t_ang;
        r3_sq   <= 62'(t_ang) * 62'(t_ang);
        r3_neg  <= r2_neg;
    end

    for (genvar j = 0; j < NSTEP; j++) begin : g_step
        logic        v_in, neg_in;
        logic [30:0] t_in;
        logic [31:0] t2_in, x_in;
        logic [31:0] q0;
        logic [39:0] rem;
        logic [31:0] q;

        if (j == 0) begin : g_first
            assign v_in   = r3_v;
            assign neg_in = r3_neg;
            assign t_in   = r3_t;
            assign t2_in  = r3_sq[61:30];
            assign x_in   = r3_sq[61:30];
        end else begin : g_next
            logic        r_pv, r_pneg;
            logic [30:0] r_pt;
            logic [31:0] r_pt2;
            logic [62:0] r_pp;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_pv <= 1'b0;
                end else begin
                    r_pv <= r_cv[j-1];
                end
            end
            always_ff @(posedge i_clk) begin
                r_pneg <= r_cneg[j-1];
                r_pt   <= r_ct[j-1];
                r_pt2  <= r_ct2[j-1];
                r_pp   <= 63'(r_ct2[j-1]) * 63'(r_ca[j-1]);
            end
            assign v_in   = r_pv;
            assign neg_in = r_pneg;
            assign t_in   = r_pt;
            assign t2_in  = r_pt2;
            assign x_in   = r_pp[61:30];
        end

        // floor(x/d): estimate is exact or one low
        assign q0  = r_mm[j][63:32];
        assign rem = 40'(r_mx[j]) - 40'(q0) * 40'(DIVISOR[j]);
        assign q   = q0 + 32'(rem >= 40'(DIVISOR[j]));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mv[j] <= 1'b0;
                r_cv[j] <= 1'b0;
            end else begin
                r_mv[j] <= v_in;
                r_cv[j] <= r_mv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_mneg[j] <= neg_in;
            r_mt[j]   <= t_in;
            r_mt2[j]  <= t2_in;
            r_mx[j]   <= x_in;
            r_mm[j]   <= 64'(x_in) * 64'(RECIP[j]);
            r_cneg[j] <= r_mneg[j];
            r_ct[j]   <= r_mt[j];
            r_ct2[j]  <= r_mt2[j];
            r_ca[j]   <= Q30_ONE - MAG_W'(q);
        end
    end

    assign s_raw = rs_prod[61:30];
    assign s_sat = (s_raw > 32'(Q30_ONE)) ? Q30_ONE : MAG_W'(s_raw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rs_v <= 1'b0;
            rf_v <= 1'b0;
        end else begin
            rs_v <= r_cv[NSTEP-1];
            rf_v <= rs_v;
        end
    end

    always_ff @(posedge i_clk) begin
        rs_prod <= 62'(r_ct[NSTEP-1]) * 62'(r_ca[NSTEP-1]);
        rs_neg  <= r_cneg[NSTEP-1];
        rf_mag  <= s_sat;
        rf_neg  <= rs_neg && (s_sat != '0);
    end

    assign o_valid = rf_v;
    assign o_mag   = rf_mag;
    assign o_neg   = rf_neg;

endmodule

@@ design/uv_sphere_vertex_generator.sv @@
// UV sphere vertex generator: grid point in, unit-sphere position and UV out.
// Start passes through the input register, the two dividers, the phase stage,
// the sine pipes, the product stage and the output register to o_valid.
// Throughput: one vertex per cycle; busy never rises and the receiver cannot
// stall, so the pipeline simply shifts every cycle. Reset (i_rst_n low at a
// clock edge, synchronous) empties the pipeline and sets the segment count r_seg to 32.
module uv_sphere_vertex_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [uvsg_pkg::IDX_W-1:0]    i_column,
    input  logic [uvsg_pkg::IDX_W-1:0]    i_row,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [uvsg_pkg::SEG_REG_W-1:0] i_cfg_data,
    output logic                          o_valid,
    output logic [uvsg_pkg::POS_W-1:0]    o_pos_x,
    output logic [uvsg_pkg::POS_W-1:0]    o_pos_y,
    output logic [uvsg_pkg::POS_W-1:0]    o_pos_z,
    output logic [uvsg_pkg::U_W-1:0]      o_tex_u,
    output logic [uvsg_pkg::U_W-1:0]      o_tex_v
);
    import uvsg_pkg::*;

    localparam int DL = SIN_STAGES + 1;
    localparam t_phase QUARTER = ANGLE_BITS'(1) << QS;
    localparam logic [61:0] HALF46 = 62'd1 << 45;
    localparam logic [31:0] HALF16 = 32'd1 << 15;

    logic [SEG_REG_W-1:0] r_seg;

    // segment count sanitized to 1..MAX_SEGMENTS, indices clamped to it
    logic [31:0]      seg_wide;
    logic [CNT_W-1:0] seg_eff, col_c, row_c;

    logic             r_in_v;
    logic [CNT_W-1:0] r_in_seg;
    logic [N_W-1:0]   r_num_u, r_num_v;

    logic             div_u_v, div_v_v;
    logic [U_W-1:0]   div_u, div_v;

    // phase stage
    logic             r_ph_v;
    logic [U_W-1:0]   r_ph_u, r_ph_tv;
    t_phase           r_lon, r_lonc, r_lat, r_latc;

    logic             sl_v, cl_v, sa_v, ca_v;
    logic [MAG_W-1:0] sl_m, cl_m, sa_m, ca_m;
    logic             sl_n, cl_n, sa_n, ca_n;

    // UV travels beside the sine pipes
    logic [U_W-1:0]   r_dl_u [DL];
    logic [U_W-1:0]   r_dl_v [DL];

    // products of the longitude and latitude terms
    logic             r_cb_v, r_cb_nx, r_cb_nz, r_cb_ny;
    logic [61:0]      r_cb_x, r_cb_z;
    logic [MAG_W-1:0] r_cb_y;
    logic [61:0]      rx_sum, rz_sum;
    logic [31:0]      ry_sum;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= SEG_REG_W'(32);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_seg <= i_cfg_data;
        end
    end

    always_comb begin
        seg_wide = 32'(r_seg);
        if (seg_wide == 32'd0) begin
            seg_wide = 32'd1;
        end else if (seg_wide > 32'(MAX_SEGMENTS)) begin
            seg_wide = 32'(MAX_SEGMENTS);
        end
        seg_eff = CNT_W'(seg_wide);
        col_c   = (32'(i_column) > seg_wide) ? seg_eff : CNT_W'(i_column);
        row_c   = (32'(i_row) > seg_wide) ? seg_eff : CNT_W'(i_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= start && !busy;
        end
    end

    // numerators carry the round-to-nearest half divisor
    always_ff @(posedge i_clk) begin
        r_in_seg <= seg_eff;
        r_num_u  <= (N_W'(col_c) << FRAC_BITS) + N_W'(seg_eff >> 1);
        r_num_v  <= (N_W'(row_c) << FRAC_BITS) + N_W'(seg_eff >> 1);
    end

    uvsg_div u_div_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .i_num   (r_num_u),
        .i_den   (r_in_seg),
        .o_valid (div_u_v),
        .o_quo   (div_u)
    );

    uvsg_div u_div_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .i_num   (r_num_v),
        .i_den   (r_in_seg),
        .o_valid (div_v_v),
        .o_quo   (div_v)
    );

    // longitude spans a full turn, latitude half a turn
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph_v <= 1'b0;
        end else begin
            r_ph_v <= div_u_v && div_v_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ph_u  <= div_u;
        r_ph_tv <= div_v;
        r_lon   <= phase_of(div_u, ANGLE_BITS);
        r_lonc  <= phase_of(div_u, ANGLE_BITS) + QUARTER;
        r_lat   <= phase_of(div_v, ANGLE_BITS - 1);
        r_latc  <= phase_of(div_v, ANGLE_BITS - 1) + QUARTER;
    end

    uvsg_sin u_sin_lon (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r_ph_v), .i_phase (r_lon),
        .o_valid (sl_v), .o_mag (sl_m), .o_neg (sl_n)
    );

    uvsg_sin u_cos_lon (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r_ph_v), .i_phase (r_lonc),
        .o_valid (cl_v), .o_mag (cl_m), .o_neg (cl_n)
    );

    uvsg_sin u_sin_lat (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r_ph_v), .i_phase (r_lat),
        .o_valid (sa_v), .o_mag (sa_m), .o_neg (sa_n)
    );

    uvsg_sin u_cos_lat (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r_ph_v), .i_phase (r_latc),
        .o_valid (ca_v), .o_mag (ca_m), .o_neg (ca_n)
    );

    always_ff @(posedge i_clk) begin
        r_dl_u[0] <= r_ph_u;
        r_dl_v[0] <= r_ph_tv;
        for (int k = 1; k < DL; k++) begin
            r_dl_u[k] <= r_dl_u[k-1];
            r_dl_v[k] <= r_dl_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cb_v <= 1'b0;
        end else begin
            r_cb_v <= sl_v && cl_v && sa_v && ca_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cb_x  <= 62'(cl_m) * 62'(sa_m);
        r_cb_z  <= 62'(sl_m) * 62'(sa_m);
        r_cb_y  <= ca_m;
        r_cb_nx <= cl_n != sa_n;
        r_cb_nz <= sl_n != sa_n;
        r_cb_ny <= ca_n;
    end

    // round half up to Q14, saturate, then sign
    assign rx_sum = r_cb_x + HALF46;
    assign rz_sum = r_cb_z + HALF46;
    assign ry_sum = 32'(r_cb_y) + HALF16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_cb_v;
        end
    end

    always_ff @(posedge i_clk) begin
        o_pos_x <= q14_of(17'(rx_sum >> 46), r_cb_nx);
        o_pos_z <= q14_of(17'(rz_sum >> 46), r_cb_nz);
        o_pos_y <= q14_of(17'(ry_sum >> 16), r_cb_ny);
        o_tex_u <= r_dl_u[DL-1];
        o_tex_v <= r_dl_v[DL-1];
    end

endmodule
